// ===== hw/rtl/hnrg_pkg.sv =====
// ----------------------------------------------------------------------------
// hnrg_pkg
// Shared types, constants and helpers of the halo neighbor rank generator.
// ----------------------------------------------------------------------------
package hnrg_pkg;

  localparam int unsigned MAX_PARTS_PER_AXIS = 64;
  localparam int unsigned MAX_RANKS          = 4096;

  localparam int unsigned RANK_W   = 12;
  localparam int unsigned COORD_W  = 6;
  localparam int unsigned PARTS_W  = 7;
  localparam int unsigned PYZ_W    = 13;
  localparam int unsigned TOT_W    = 19;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned PER_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned NUM_BLOCKS = 7;
  localparam int unsigned NUM_SLOTS  = 2 * NUM_BLOCKS;
  localparam int unsigned SLOT_W     = 4;

  // periodic mask bits
  localparam int unsigned PER_X = 0;
  localparam int unsigned PER_Y = 1;
  localparam int unsigned PER_Z = 2;

  // axis set bits of a block
  localparam int unsigned AX_Z = 0;
  localparam int unsigned AX_Y = 1;
  localparam int unsigned AX_X = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PARTS_X  = 2'd0,
    REG_PARTS_Y  = 2'd1,
    REG_PARTS_Z  = 2'd2,
    REG_PERIODIC = 2'd3
  } hnrg_reg_e;

  typedef struct packed {
    logic [PARTS_W-1:0] px;
    logic [PARTS_W-1:0] py;
    logic [PARTS_W-1:0] pz;
    logic [PYZ_W-1:0]   pyz;
    logic [TOT_W-1:0]   total;
    logic [PER_W-1:0]   periodic;
  } hnrg_geom_t;

  typedef struct packed {
    logic               err;
    logic [RANK_W-1:0]  rank;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cz;
  } hnrg_item_t;

  typedef struct packed {
    logic               present;
    logic               is_recv;
    logic [CODE_W-1:0]  block_code;
    logic [RANK_W-1:0]  partner_rank;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic               rank_error;
    logic               last;
  } hnrg_result_t;

  function automatic logic [PARTS_W-1:0] eff_parts(input logic [PARTS_W-1:0] raw);
    logic [PARTS_W-1:0] res;
    res = raw;
    if (raw == '0) begin
      res = PARTS_W'(1);
    end else if (raw > PARTS_W'(MAX_PARTS_PER_AXIS)) begin
      res = PARTS_W'(MAX_PARTS_PER_AXIS);
    end
    return res;
  endfunction

  // axis set per block code: bit0 z, bit1 y, bit2 x
  function automatic logic [2:0] block_axes(input logic [CODE_W-1:0] code);
    logic [2:0] ax;
    case (code)
      3'd0:    ax = 3'b001;
      3'd1:    ax = 3'b010;
      3'd2:    ax = 3'b100;
      3'd3:    ax = 3'b011;
      3'd4:    ax = 3'b101;
      3'd5:    ax = 3'b110;
      3'd6:    ax = 3'b111;
      default: ax = 3'b000;
    endcase
    return ax;
  endfunction

endpackage

// ===== hw/rtl/hnrg_cfg.sv =====
// ----------------------------------------------------------------------------
// hnrg_cfg
// Configuration registers and registered grid products.
// ----------------------------------------------------------------------------
module hnrg_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [hnrg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [hnrg_pkg::PARTS_W-1:0]         cfg_wdata_i,
  output hnrg_pkg::hnrg_geom_t                 geom_o
);
  import hnrg_pkg::*;

  logic [PARTS_W-1:0] px_q, py_q, pz_q;
  logic [PER_W-1:0]   per_q;
  logic [PYZ_W-1:0]   pyz_q;
  logic [TOT_W-1:0]   tot_q;
  logic [2*PARTS_W-1:0]       pyz_full;
  logic [PARTS_W+PYZ_W-1:0]   tot_full;
  hnrg_reg_e          idx;

  assign idx      = hnrg_reg_e'(cfg_idx_i);
  assign pyz_full = py_q * pz_q;
  assign tot_full = px_q * pyz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q  <= PARTS_W'(1);
      py_q  <= PARTS_W'(1);
      pz_q  <= PARTS_W'(1);
      per_q <= '0;
      pyz_q <= PYZ_W'(1);
      tot_q <= TOT_W'(1);
    end else begin
      pyz_q <= pyz_full[PYZ_W-1:0];
      tot_q <= tot_full[TOT_W-1:0];
      if (cfg_we_i) begin
        case (idx)
          REG_PARTS_X:  px_q  <= eff_parts(cfg_wdata_i);
          REG_PARTS_Y:  py_q  <= eff_parts(cfg_wdata_i);
          REG_PARTS_Z:  pz_q  <= eff_parts(cfg_wdata_i);
          REG_PERIODIC: per_q <= cfg_wdata_i[PER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign geom_o.px       = px_q;
  assign geom_o.py       = py_q;
  assign geom_o.pz       = pz_q;
  assign geom_o.pyz      = pyz_q;
  assign geom_o.total    = tot_q;
  assign geom_o.periodic = per_q;

endmodule

// ===== hw/rtl/hnrg_front.sv =====
// ----------------------------------------------------------------------------
// hnrg_front
// Accepts ranks, checks range and splits them into coordinates in a
// pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module hnrg_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hnrg_pkg::hnrg_geom_t             geom_i,
  input  logic                             in_vld_i,
  input  logic [hnrg_pkg::RANK_W-1:0]      in_rank_i,
  output logic                             in_full_o,
  output logic                             q_wr_o,
  output hnrg_pkg::hnrg_item_t             q_item_o,
  input  logic                             q_full_i
);
  import hnrg_pkg::*;

  localparam int unsigned NUM_DIV = 2 * COORD_W;
  localparam int unsigned NSTG    = 3 + NUM_DIV;
  localparam int unsigned DIV_W   = PYZ_W + COORD_W - 1;

  typedef struct packed {
    logic               err;
    logic [RANK_W-1:0]  rank;
    logic [RANK_W-1:0]  rem;
    logic [COORD_W-1:0] qx;
    logic [COORD_W-1:0] qy;
  } stage_t;

  logic   vld_q [NSTG];
  stage_t stg_q [NSTG];
  stage_t stg_d [NSTG];
  logic   en;

  assign en        = !vld_q[NSTG-1] || !q_full_i;
  assign in_full_o = !en;
  assign q_wr_o    = vld_q[NSTG-1] && !q_full_i;

  always_comb begin
    logic [DIV_W-1:0] dv;
    int unsigned      bi;
    stg_d[0]      = stg_q[0];
    stg_d[0].rank = in_rank_i;
    stg_d[0].err  = 1'b0;
    stg_d[1]      = stg_q[0];
    stg_d[2]      = stg_q[1];
    stg_d[2].err  = (geom_i.total > TOT_W'(MAX_RANKS)) ||
                    (TOT_W'(stg_q[1].rank) >= geom_i.total);
    stg_d[2].rem  = stg_q[1].rank;
    stg_d[2].qx   = '0;
    stg_d[2].qy   = '0;
    for (int k = 0; k < NUM_DIV; k++) begin
      stg_d[3+k] = stg_q[2+k];
      if (k < COORD_W) begin
        bi = COORD_W - 1 - k;
        dv = DIV_W'(geom_i.pyz) << bi;
      end else begin
        bi = NUM_DIV - 1 - k;
        dv = DIV_W'(geom_i.pz) << bi;
      end
      if (DIV_W'(stg_q[2+k].rem) >= dv) begin
        stg_d[3+k].rem = stg_q[2+k].rem - dv[RANK_W-1:0];
        if (k < COORD_W) begin
          stg_d[3+k].qx[bi] = 1'b1;
        end else begin
          stg_d[3+k].qy[bi] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NSTG; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_vld_i;
      for (int s = 1; s < NSTG; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < NSTG; s++) begin
        stg_q[s] <= stg_d[s];
      end
    end
  end

  assign q_item_o.err  = stg_q[NSTG-1].err;
  assign q_item_o.rank = stg_q[NSTG-1].rank;
  assign q_item_o.cx   = stg_q[NSTG-1].qx;
  assign q_item_o.cy   = stg_q[NSTG-1].qy;
  assign q_item_o.cz   = stg_q[NSTG-1].rem[COORD_W-1:0];

endmodule

// ===== hw/rtl/hnrg_queue.sv =====
// ----------------------------------------------------------------------------
// hnrg_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module hnrg_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  hnrg_pkg::hnrg_item_t  wr_data_i,
  output logic                  full_o,
  input  logic                  rd_en_i,
  output hnrg_pkg::hnrg_item_t  rd_data_o,
  output logic                  empty_o
);
  import hnrg_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  hnrg_item_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             wr, rd;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr      = wr_en_i && !full_o;
  assign rd      = rd_en_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (wr && !rd) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (rd && !wr) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/hnrg_back.sv =====
// ----------------------------------------------------------------------------
// hnrg_back
// Walks the send and receive neighbor slots of one rank and emits partners
// through an output register, or one result for an out-of-range or isolated rank.
// ----------------------------------------------------------------------------
module hnrg_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hnrg_pkg::hnrg_geom_t  geom_i,
  input  logic                  q_empty_i,
  input  hnrg_pkg::hnrg_item_t  q_item_i,
  output logic                  q_pop_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output hnrg_pkg::hnrg_result_t res_o
);
  import hnrg_pkg::*;

  localparam logic [CODE_W-1:0] BLK_LAST = CODE_W'(NUM_BLOCKS - 1);

  logic                 busy_q;
  logic                 special_q;
  logic [NUM_SLOTS-1:0] mask_q;
  logic                 side_q;
  logic [CODE_W-1:0]    blk_q;
  hnrg_item_t           item_q;
  logic [RANK_W-1:0]    dlo_q [3];
  logic [RANK_W-1:0]    dhi_q [3];
  logic                 out_vld_q;
  hnrg_result_t         res_q;

  // load-side decode
  logic                 lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic [2:0]           ok_lo, ok_hi;
  logic [NUM_SLOTS-1:0] mask_d;
  logic [RANK_W-1:0]    dlo_d [3];
  logic [RANK_W-1:0]    dhi_d [3];
  logic [RANK_W-1:0]    pz_w, pyz_w, tot_w, span_y, span_x;

  // walk-side decode
  logic                 can_emit;
  logic                 emit;
  logic [SLOT_W-1:0]    idx;
  logic [NUM_SLOTS-1:0] rest;
  logic                 cur;
  logic [2:0]           ax;
  logic [RANK_W-1:0]    partner;
  logic [RANK_W-1:0]    dsel [3];

  assign q_pop_o = !busy_q && !q_empty_i;

  always_comb begin
    lo_x = (q_item_i.cx == '0);
    lo_y = (q_item_i.cy == '0);
    lo_z = (q_item_i.cz == '0);
    hi_x = ({1'b0, q_item_i.cx} == geom_i.px - PARTS_W'(1));
    hi_y = ({1'b0, q_item_i.cy} == geom_i.py - PARTS_W'(1));
    hi_z = ({1'b0, q_item_i.cz} == geom_i.pz - PARTS_W'(1));
    ok_lo[AX_Z] = geom_i.periodic[PER_Z] || !lo_z;
    ok_lo[AX_Y] = geom_i.periodic[PER_Y] || !lo_y;
    ok_lo[AX_X] = geom_i.periodic[PER_X] || !lo_x;
    ok_hi[AX_Z] = geom_i.periodic[PER_Z] || !hi_z;
    ok_hi[AX_Y] = geom_i.periodic[PER_Y] || !hi_y;
    ok_hi[AX_X] = geom_i.periodic[PER_X] || !hi_x;
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      mask_d[b]            = ((block_axes(CODE_W'(b)) & ok_lo) == block_axes(CODE_W'(b)));
      mask_d[NUM_BLOCKS+b] = ((block_axes(CODE_W'(b)) & ok_hi) == block_axes(CODE_W'(b)));
    end
    pz_w   = RANK_W'(geom_i.pz);
    pyz_w  = geom_i.pyz[RANK_W-1:0];
    tot_w  = geom_i.total[RANK_W-1:0];
    span_y = pyz_w - pz_w;
    span_x = tot_w - pyz_w;
    dlo_d[AX_Z] = lo_z ? pz_w - RANK_W'(1) : RANK_W'(0) - RANK_W'(1);
    dhi_d[AX_Z] = hi_z ? RANK_W'(1) - pz_w : RANK_W'(1);
    dlo_d[AX_Y] = lo_y ? span_y : RANK_W'(0) - pz_w;
    dhi_d[AX_Y] = hi_y ? RANK_W'(0) - span_y : pz_w;
    dlo_d[AX_X] = lo_x ? span_x : RANK_W'(0) - pyz_w;
    dhi_d[AX_X] = hi_x ? RANK_W'(0) - span_x : pyz_w;
  end

  always_comb begin
    can_emit = !out_vld_q || pop_i;
    idx      = side_q ? SLOT_W'(blk_q) + SLOT_W'(NUM_BLOCKS) : SLOT_W'(blk_q);
    cur      = mask_q[idx];
    emit     = busy_q && can_emit && (special_q || cur);
    rest     = mask_q & ~(NUM_SLOTS'(1) << idx);
    ax       = block_axes(blk_q);
    for (int a = 0; a < 3; a++) begin
      dsel[a] = side_q ? dhi_q[a] : dlo_q[a];
    end
    partner = item_q.rank
            + (ax[AX_Z] ? dsel[AX_Z] : '0)
            + (ax[AX_Y] ? dsel[AX_Y] : '0)
            + (ax[AX_X] ? dsel[AX_X] : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
      special_q <= 1'b0;
      mask_q    <= '0;
      side_q    <= 1'b0;
      blk_q     <= '0;
    end else begin
      if (pop_i && !emit) begin
        out_vld_q <= 1'b0;
      end
      if (q_pop_o) begin
        busy_q    <= 1'b1;
        special_q <= q_item_i.err || (mask_d == '0);
        mask_q    <= mask_d;
        side_q    <= 1'b0;
        blk_q     <= '0;
      end else if (busy_q) begin
        if (special_q) begin
          if (can_emit) begin
            out_vld_q <= 1'b1;
            busy_q    <= 1'b0;
          end
        end else if (!cur || can_emit) begin
          if (cur) begin
            out_vld_q <= 1'b1;
            mask_q    <= rest;
          end
          if (cur && (rest == '0)) begin
            busy_q <= 1'b0;
          end else if (blk_q == BLK_LAST) begin
            blk_q  <= '0;
            side_q <= 1'b1;
          end else begin
            blk_q <= blk_q + CODE_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
      for (int a = 0; a < 3; a++) begin
        dlo_q[a] <= dlo_d[a];
        dhi_q[a] <= dhi_d[a];
      end
    end
    if (emit) begin
      res_q.present      <= !special_q;
      res_q.is_recv      <= special_q ? 1'b0 : side_q;
      res_q.block_code   <= special_q ? '0 : blk_q;
      res_q.partner_rank <= special_q ? '0 : partner;
      res_q.coord_x      <= item_q.err ? '0 : item_q.cx;
      res_q.coord_y      <= item_q.err ? '0 : item_q.cy;
      res_q.coord_z      <= item_q.err ? '0 : item_q.cz;
      res_q.rank_error   <= item_q.err;
      res_q.last         <= special_q || (rest == '0);
    end
  end

  assign empty_o = !out_vld_q;
  assign res_o   = res_q;

endmodule

// ===== hw/rtl/halo_neighbor_rank_generator_top.sv =====
// ----------------------------------------------------------------------------
// halo_neighbor_rank_generator_top
// Splits a rank into 3D grid coordinates and lists its lower (send) and
// upper (receive) neighbor ranks.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+------------------------------
//   input    | in        | push / full         | rank_in_i
//   result   | out       | empty / pop         | present_o .. last_o
//   config   | in        | cfg_we_i            | cfg_idx_i, cfg_wdata_i
//
// The front takes one rank transaction per cycle while full is low; it reaches
// the queue through the input registers, the range check and the divider stages.
// The back loads a rank and then walks its neighbor slots, up to fourteen, in
// order, and loads no new rank until the walk is done.
// After a configuration write the registered py*pz product settles, then the total.
// Reset gives a 1x1x1 grid with no periodic axis and empties every stage.
// A stalled result holds the back; the queue and the front then fill and
// raise full.
// ----------------------------------------------------------------------------
module halo_neighbor_rank_generator_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [hnrg_pkg::RANK_W-1:0]       rank_in_i,
  output logic                              empty,
  input  logic                              pop,
  output logic                              present_o,
  output logic                              is_recv_o,
  output logic [hnrg_pkg::CODE_W-1:0]       block_code_o,
  output logic [hnrg_pkg::RANK_W-1:0]       partner_rank_o,
  output logic [hnrg_pkg::COORD_W-1:0]      coord_x_o,
  output logic [hnrg_pkg::COORD_W-1:0]      coord_y_o,
  output logic [hnrg_pkg::COORD_W-1:0]      coord_z_o,
  output logic                              rank_error_o,
  output logic                              last_o,
  input  logic                              cfg_we_i,
  input  logic [hnrg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hnrg_pkg::PARTS_W-1:0]      cfg_wdata_i
);
  import hnrg_pkg::*;

  hnrg_geom_t   geom;
  logic         q_wr, q_full, q_empty, q_pop;
  hnrg_item_t   f_item, q_item;
  hnrg_result_t res;

  hnrg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .geom_o      (geom)
  );

  hnrg_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .geom_i    (geom),
    .in_vld_i  (push),
    .in_rank_i (rank_in_i),
    .in_full_o (full),
    .q_wr_o    (q_wr),
    .q_item_o  (f_item),
    .q_full_i  (q_full)
  );

  hnrg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (q_wr),
    .wr_data_i (f_item),
    .full_o    (q_full),
    .rd_en_i   (q_pop),
    .rd_data_o (q_item),
    .empty_o   (q_empty)
  );

  hnrg_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .geom_i    (geom),
    .q_empty_i (q_empty),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res)
  );

  assign present_o      = res.present;
  assign is_recv_o      = res.is_recv;
  assign block_code_o   = res.block_code;
  assign partner_rank_o = res.partner_rank;
  assign coord_x_o      = res.coord_x;
  assign coord_y_o      = res.coord_y;
  assign coord_z_o      = res.coord_z;
  assign rank_error_o   = res.rank_error;
  assign last_o         = res.last;

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the halo neighbor rank generator. Ranks are pushed
// over a series of grid shapes and periodic masks; a scoreboard works out
// every send and receive partner of each accepted rank and checks the result
// stream field by field, in order, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  import hnrg_pkg::*;

  typedef enum int unsigned {
    BLK_Z, BLK_Y, BLK_X, BLK_YZ, BLK_XZ, BLK_XY, BLK_XYZ
  } blk_e;

  class partner_scoreboard;
    logic [PARTS_W-1:0] raw_x;
    logic [PARTS_W-1:0] raw_y;
    logic [PARTS_W-1:0] raw_z;
    logic [PER_W-1:0]   wrap_mask;
    hnrg_result_t       pending_partners[$];
    int unsigned n_ranks, n_results, n_partners, n_bad_ranks, n_isolated, n_errors;

    function new();
      raw_x = 1;
      raw_y = 1;
      raw_z = 1;
      wrap_mask = '0;
    endfunction

    function void write_reg(hnrg_reg_e idx, logic [PARTS_W-1:0] val);
      case (idx)
        REG_PARTS_X:  raw_x = val;
        REG_PARTS_Y:  raw_y = val;
        REG_PARTS_Z:  raw_z = val;
        REG_PERIODIC: wrap_mask = val[PER_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned axis_parts(logic [PARTS_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > MAX_PARTS_PER_AXIS) return MAX_PARTS_PER_AXIS;
      return raw;
    endfunction

    function int unsigned grid_total();
      return axis_parts(raw_x) * axis_parts(raw_y) * axis_parts(raw_z);
    endfunction

    // bit0 z, bit1 y, bit2 x
    function logic [2:0] axes_of(blk_e blk);
      case (blk)
        BLK_Z:   return 3'b001;
        BLK_Y:   return 3'b010;
        BLK_X:   return 3'b100;
        BLK_YZ:  return 3'b011;
        BLK_XZ:  return 3'b101;
        BLK_XY:  return 3'b110;
        default: return 3'b111;
      endcase
    endfunction

    function void queue_partners(logic [RANK_W-1:0] rank);
      int unsigned px, py, pz, pyz, total, cx, cy, cz, nx, ny, nz;
      logic [2:0] lo_ok, hi_ok, ok, ax;
      hnrg_result_t r;
      int found;
      n_ranks++;
      px = axis_parts(raw_x);
      py = axis_parts(raw_y);
      pz = axis_parts(raw_z);
      pyz = py * pz;
      total = px * pyz;
      r = '0;
      if (total > MAX_RANKS || rank >= total) begin
        r.rank_error = 1'b1;
        r.last = 1'b1;
        pending_partners.push_back(r);
        n_bad_ranks++;
        return;
      end
      cx = rank / pyz;
      cy = (rank % pyz) / pz;
      cz = rank % pz;
      lo_ok[AX_Z] = wrap_mask[PER_Z] || cz != 0;
      lo_ok[AX_Y] = wrap_mask[PER_Y] || cy != 0;
      lo_ok[AX_X] = wrap_mask[PER_X] || cx != 0;
      hi_ok[AX_Z] = wrap_mask[PER_Z] || cz != pz - 1;
      hi_ok[AX_Y] = wrap_mask[PER_Y] || cy != py - 1;
      hi_ok[AX_X] = wrap_mask[PER_X] || cx != px - 1;
      r.coord_x = COORD_W'(cx);
      r.coord_y = COORD_W'(cy);
      r.coord_z = COORD_W'(cz);
      found = 0;
      for (int side = 0; side < 2; side++) begin
        ok = side ? hi_ok : lo_ok;
        for (int b = BLK_Z; b <= BLK_XYZ; b++) begin
          ax = axes_of(blk_e'(b));
          if ((ax & ok) == ax) begin
            nx = cx;
            ny = cy;
            nz = cz;
            if (ax[AX_Z]) nz = side ? (cz + 1) % pz : (cz + pz - 1) % pz;
            if (ax[AX_Y]) ny = side ? (cy + 1) % py : (cy + py - 1) % py;
            if (ax[AX_X]) nx = side ? (cx + 1) % px : (cx + px - 1) % px;
            r.present = 1'b1;
            r.is_recv = side[0];
            r.block_code = CODE_W'(b);
            r.partner_rank = RANK_W'(nx * pyz + ny * pz + nz);
            pending_partners.push_back(r);
            found++;
          end
        end
      end
      if (found == 0) begin
        r.last = 1'b1;
        pending_partners.push_back(r);
        n_isolated++;
      end else begin
        r = pending_partners.pop_back();
        r.last = 1'b1;
        pending_partners.push_back(r);
        n_partners += found;
      end
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        n_errors++;
      end
    endfunction

    function void check_partner(hnrg_result_t got);
      hnrg_result_t want;
      n_results++;
      if (pending_partners.size() == 0) begin
        $error("unexpected result transaction: partner_rank %0d", got.partner_rank);
        n_errors++;
        return;
      end
      want = pending_partners.pop_front();
      compare("present", want.present, got.present);
      compare("is_recv", want.is_recv, got.is_recv);
      compare("block_code", want.block_code, got.block_code);
      compare("partner_rank", want.partner_rank, got.partner_rank);
      compare("coord_x", want.coord_x, got.coord_x);
      compare("coord_y", want.coord_y, got.coord_y);
      compare("coord_z", want.coord_z, got.coord_z);
      compare("rank_error", want.rank_error, got.rank_error);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic [RANK_W-1:0]    rank_in_i;
  logic                 empty;
  logic                 pop;
  logic                 present_o;
  logic                 is_recv_o;
  logic [CODE_W-1:0]    block_code_o;
  logic [RANK_W-1:0]    partner_rank_o;
  logic [COORD_W-1:0]   coord_x_o;
  logic [COORD_W-1:0]   coord_y_o;
  logic [COORD_W-1:0]   coord_z_o;
  logic                 rank_error_o;
  logic                 last_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [PARTS_W-1:0]   cfg_wdata_i;

  partner_scoreboard book;
  int unsigned       tx_idle_pct;
  int unsigned       rx_idle_pct;
  bit                hold_request;
  int unsigned       n_settings;

  halo_neighbor_rank_generator_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .rank_in_i      (rank_in_i),
    .empty          (empty),
    .pop            (pop),
    .present_o      (present_o),
    .is_recv_o      (is_recv_o),
    .block_code_o   (block_code_o),
    .partner_rank_o (partner_rank_o),
    .coord_x_o      (coord_x_o),
    .coord_y_o      (coord_y_o),
    .coord_z_o      (coord_z_o),
    .rank_error_o   (rank_error_o),
    .last_o         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) book.queue_partners(rank_in_i);
      if (pop && !empty) begin
        book.check_partner(hnrg_result_t'{present_o, is_recv_o, block_code_o,
                                          partner_rank_o, coord_x_o, coord_y_o,
                                          coord_z_o, rank_error_o, last_o});
      end
    end
  end

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_left = 300;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_rank(logic [RANK_W-1:0] r);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    rank_in_i <= r;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (book.pending_partners.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(hnrg_reg_e idx, logic [PARTS_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    book.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic reconfigure(logic [PARTS_W-1:0] px, logic [PARTS_W-1:0] py,
                             logic [PARTS_W-1:0] pz, logic [PER_W-1:0] mask);
    drain();
    write_reg(REG_PARTS_X, px);
    write_reg(REG_PARTS_Y, py);
    write_reg(REG_PARTS_Z, pz);
    write_reg(REG_PERIODIC, PARTS_W'(mask));
    cfg_we_i <= 1'b0;
    // hold until the grid products settle
    repeat (4) @(posedge clk_i);
    n_settings++;
  endtask

  function automatic logic [PARTS_W-1:0] rand_parts();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return PARTS_W'($urandom_range(MAX_PARTS_PER_AXIS + 1, 127));
    if (pick <= 3) return PARTS_W'(MAX_PARTS_PER_AXIS);
    return PARTS_W'($urandom_range(1, 6));
  endfunction

  function automatic logic [RANK_W-1:0] pick_rank();
    int unsigned total;
    total = book.grid_total();
    if (total > MAX_RANKS || $urandom_range(0, 9) < 2) return RANK_W'($urandom);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return RANK_W'(total - 1);
      default: return RANK_W'($urandom_range(0, total - 1));
    endcase
  endfunction

  initial begin
    book = new();
    rst_ni <= 1'b0;
    push <= 1'b0;
    rank_in_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_PARTS_X;
    cfg_wdata_i <= '0;
    tx_idle_pct = 22;
    rx_idle_pct = 22;
    hold_request = 1'b0;
    n_settings = 1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset grid: single part, no wrap
    send_rank(0);
    send_rank(1);
    send_rank(12'hFFF);

    // single part on every periodic axis: all partners are the rank itself
    reconfigure(1, 1, 1, 3'b111);
    send_rank(0);

    reconfigure(4, 3, 5, 3'b111);
    send_rank(0);
    send_rank(59);
    send_rank(22);
    send_rank(60);
    send_rank(12'hFFF);

    reconfigure(4, 3, 5, 3'b000);
    send_rank(0);
    send_rank(59);
    send_rank(22);

    // full-size grid, largest coordinates
    reconfigure(64, 64, 1, 3'b001);
    send_rank(12'hFFF);
    send_rank(0);
    send_rank(2048);
    send_rank(4094);

    // zero and oversized part counts
    reconfigure(0, 127, 3, 3'b110);
    send_rank(0);
    send_rank(191);
    send_rank(192);
    send_rank(100);

    // grid larger than the rank space
    reconfigure(64, 64, 2, 3'b111);
    send_rank(0);
    send_rank(12'hFFF);

    for (int ph = 0; ph < 6; ph++) begin
      reconfigure(rand_parts(), rand_parts(), rand_parts(), PER_W'($urandom_range(0, 7)));
      tx_idle_pct = (ph == 2) ? 0 : 22;
      rx_idle_pct = (ph == 2) ? 0 : 22;
      if (ph == 0) hold_request = 1'b1;
      repeat (21) send_rank(pick_rank());
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (book.pending_partners.size() != 0) begin
      $error("%0d partner results never arrived", book.pending_partners.size());
    end
    $display("Covered %0d ranks over %0d grid settings, %0d result transactions checked.",
             book.n_ranks, n_settings, book.n_results);
    $display("Partners %0d, out-of-range ranks %0d, ranks without partners %0d.",
             book.n_partners, book.n_bad_ranks, book.n_isolated);
    if (book.n_errors == 0 && book.pending_partners.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hnrg_pkg.sv
hw/rtl/hnrg_cfg.sv
hw/rtl/hnrg_front.sv
hw/rtl/hnrg_queue.sv
hw/rtl/hnrg_back.sv
hw/rtl/halo_neighbor_rank_generator_top.sv
sim/tb.sv
